@@ design/pdcal_pkg.sv @@
package pdcal_pkg;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_PREV  = 2'd3
  } cmd_t;

  // The year is kept as hundreds and units so that the leap rule needs no division.
  typedef struct packed {
    logic [7:0] year_hi;
    logic [6:0] year_lo;
    logic [6:0] month;
    logic [6:0] day;
  } date_t;

  typedef struct packed {
    cmd_t       cmd;
    date_t      date;
  } split_t;

  typedef struct packed {
    date_t      date;
    logic       limit_hit;
  } step_t;

  // Exact unsigned division by 100 for any 32-bit value: multiply, then shift by 37.
  localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;

  function automatic logic leap_of(logic [7:0] year_hi, logic [6:0] year_lo);
    logic leap;
    if (year_lo == 7'd0) begin
      leap = (year_hi[1:0] == 2'b00);
    end else begin
      leap = (year_lo[1:0] == 2'b00);
    end
    return leap;
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [6:0] month);
    logic [4:0] len;
    case (month) inside
      7'd2:                    len = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

@@ design/pdcal_split.sv @@
module pdcal_split (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [26:0]       in_load_date,
  output logic              split_valid,
  input  logic              split_stall,
  output pdcal_pkg::split_t split_data
);
  import pdcal_pkg::*;

  function automatic logic [20:0] div100(logic [26:0] x);
    logic [57:0] prod;
    prod = 58'(x) * 58'(DIV100_MAGIC);
    return prod[57:37];
  endfunction

  // Only the low bits matter: the remainder is below 100.
  function automatic logic [6:0] rem100(logic [6:0] x_low, logic [6:0] q_low);
    return 7'(x_low - 7'(q_low * 7'd100));
  endfunction

  logic [3:0]  v_r;
  logic [3:0]  hold;

  cmd_t        cmd1_r, cmd2_r, cmd3_r;
  logic [26:0] ld1_r;
  logic [20:0] q1_r;
  logic [6:0]  d2_r, d3_r, m3_r;
  logic [20:0] x2_r;
  logic [13:0] q2_r, y3_r;
  logic [7:0]  q3_r;
  split_t      split_r;

  logic [20:0] q2_full, q3_full;

  assign hold[3] = v_r[3] & split_stall;
  assign hold[2] = v_r[2] & hold[3];
  assign hold[1] = v_r[1] & hold[2];
  assign hold[0] = v_r[0] & hold[1];

  assign in_stall    = hold[0];
  assign split_valid = v_r[3];
  assign split_data  = split_r;

  assign q2_full = div100(27'(q1_r));
  assign q3_full = div100(27'(q2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (!hold[0]) v_r[0] <= in_valid;
      if (!hold[1]) v_r[1] <= v_r[0];
      if (!hold[2]) v_r[2] <= v_r[1];
      if (!hold[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      cmd1_r <= cmd_t'(in_command);
      ld1_r  <= in_load_date;
      q1_r   <= div100(in_load_date);
    end
    if (!hold[1]) begin
      cmd2_r <= cmd1_r;
      d2_r   <= rem100(ld1_r[6:0], q1_r[6:0]);
      x2_r   <= q1_r;
      q2_r   <= q2_full[13:0];
    end
    if (!hold[2]) begin
      cmd3_r <= cmd2_r;
      d3_r   <= d2_r;
      m3_r   <= rem100(x2_r[6:0], q2_r[6:0]);
      y3_r   <= q2_r;
      q3_r   <= q3_full[7:0];
    end
    if (!hold[3]) begin
      split_r.cmd          <= cmd3_r;
      split_r.date.year_hi <= q3_r;
      split_r.date.year_lo <= rem100(y3_r[6:0], q3_r[6:0]);
      split_r.date.month   <= m3_r;
      split_r.date.day     <= d3_r;
    end
  end

endmodule

@@ design/pdcal_step.sv @@
module pdcal_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              split_valid,
  output logic              split_stall,
  input  pdcal_pkg::split_t split_data,
  output logic              date_valid,
  input  logic              date_stall,
  output pdcal_pkg::step_t  date_data
);
  import pdcal_pkg::*;

  logic       v_r;
  logic       hold;
  date_t      date_r, date_nxt;
  logic       hit_r, hit_nxt;

  logic       leap;
  logic [4:0] len_cur, len_prv;
  logic [7:0] hi_inc, hi_dec;
  logic [6:0] lo_inc, lo_dec;
  logic       ge_top, gt_top, le_low, year_zero;

  assign hold        = v_r & date_stall;
  assign split_stall = hold;
  assign date_valid  = v_r;
  assign date_data   = '{date: date_r, limit_hit: hit_r};

  assign leap    = leap_of(date_r.year_hi, date_r.year_lo);
  assign len_cur = month_len(leap, date_r.month);
  assign len_prv = month_len(leap, 7'(date_r.month - 7'd1));

  assign hi_inc = (date_r.year_lo == 7'd99) ? 8'(date_r.year_hi + 8'd1) : date_r.year_hi;
  assign lo_inc = (date_r.year_lo == 7'd99) ? 7'd0 : 7'(date_r.year_lo + 7'd1);
  assign hi_dec = (date_r.year_lo == 7'd0) ? 8'(date_r.year_hi - 8'd1) : date_r.year_hi;
  assign lo_dec = (date_r.year_lo == 7'd0) ? 7'd99 : 7'(date_r.year_lo - 7'd1);

  // Digit-wise comparison against 99991231 and 00000101; every part is below 100
  // except the hundreds of the year, so the order matches the packed number.
  assign ge_top = (date_r.year_hi > 8'd99) ||
                  (date_r.year_hi == 8'd99 && (date_r.year_lo > 7'd99 ||
                   (date_r.year_lo == 7'd99 && (date_r.month > 7'd12 ||
                    (date_r.month == 7'd12 && date_r.day >= 7'd31)))));
  assign gt_top = (date_r.year_hi > 8'd99) ||
                  (date_r.year_hi == 8'd99 && (date_r.year_lo > 7'd99 ||
                   (date_r.year_lo == 7'd99 && (date_r.month > 7'd12 ||
                    (date_r.month == 7'd12 && date_r.day > 7'd31)))));
  assign year_zero = (date_r.year_hi == 8'd0) && (date_r.year_lo == 7'd0);
  assign le_low = year_zero &&
                  (date_r.month == 7'd0 || (date_r.month == 7'd1 && date_r.day <= 7'd1));

  always_comb begin
    date_nxt = date_r;
    hit_nxt  = 1'b0;
    unique case (split_data.cmd)
      CMD_QUERY: begin
        date_nxt = date_r;
      end
      CMD_LOAD: begin
        date_nxt = split_data.date;
      end
      CMD_NEXT: begin
        if (ge_top) begin
          hit_nxt = 1'b1;
        end else if (date_r.month == 7'd0) begin
          date_nxt.month = 7'd1;
          date_nxt.day   = 7'd1;
        end else if (date_r.month > 7'd12) begin
          date_nxt = '{year_hi: hi_inc, year_lo: lo_inc, month: 7'd1, day: 7'd1};
        end else if (date_r.day < 7'(len_cur)) begin
          date_nxt.day = 7'(date_r.day + 7'd1);
        end else if (date_r.month < 7'd12) begin
          date_nxt.month = 7'(date_r.month + 7'd1);
          date_nxt.day   = 7'd1;
        end else begin
          date_nxt = '{year_hi: hi_inc, year_lo: lo_inc, month: 7'd1, day: 7'd1};
        end
      end
      CMD_PREV: begin
        if (le_low) begin
          hit_nxt = 1'b1;
        end else if (gt_top) begin
          date_nxt = '{year_hi: 8'd99, year_lo: 7'd99, month: 7'd12, day: 7'd31};
        end else if (date_r.month > 7'd12) begin
          date_nxt.month = 7'd12;
          date_nxt.day   = 7'd31;
        end else if (date_r.month != 7'd0 && date_r.day > 7'(len_cur)) begin
          date_nxt.day = 7'(len_cur);
        end else if (date_r.month != 7'd0 && date_r.day > 7'd1) begin
          date_nxt.day = 7'(date_r.day - 7'd1);
        end else if (date_r.month > 7'd1) begin
          date_nxt.month = 7'(date_r.month - 7'd1);
          date_nxt.day   = 7'(len_prv);
        end else if (year_zero) begin
          hit_nxt = 1'b1;
        end else begin
          date_nxt = '{year_hi: hi_dec, year_lo: lo_dec, month: 7'd12, day: 7'd31};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      date_r <= '0;
    end else if (!hold) begin
      v_r <= split_valid;
      if (split_valid) begin
        date_r <= date_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && split_valid) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

@@ design/pdcal_fields.sv @@
module pdcal_fields (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             date_valid,
  output logic             date_stall,
  input  pdcal_pkg::step_t date_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [26:0]      out_current_value,
  output logic [13:0]      out_year_part,
  output logic [6:0]       out_month_part,
  output logic [6:0]       out_day_part,
  output logic [5:0]       out_quarter_number,
  output logic             out_leap_flag,
  output logic             out_valid_flag,
  output logic [8:0]       out_ordinal_day,
  output logic [8:0]       out_days_remaining,
  output logic             out_limit_hit
);
  import pdcal_pkg::*;

  logic        va_r, vb_r;
  logic        hold_a, hold_b;

  logic [13:0] ya_r;
  logic [6:0]  ma_r, da_r;
  logic        leapa_r, valida_r, hita_r;
  logic [8:0]  orda_r;
  logic [5:0]  qa_r;

  logic [26:0] value_r;
  logic [13:0] yb_r;
  logic [6:0]  mb_r, db_r;
  logic [5:0]  qb_r;
  logic        leapb_r, validb_r, hitb_r;
  logic [8:0]  ordb_r, remb_r;

  logic        leap_nxt, valid_nxt;
  logic [4:0]  len;
  logic [8:0]  ord_nxt;
  logic [15:0] qprod;

  assign hold_b     = vb_r & out_stall;
  assign hold_a     = va_r & hold_b;
  assign date_stall = hold_a;

  assign leap_nxt  = leap_of(date_data.date.year_hi, date_data.date.year_lo);
  assign len       = month_len(leap_nxt, date_data.date.month);
  assign valid_nxt = (date_data.date.month >= 7'd1) && (date_data.date.month <= 7'd12) &&
                     (date_data.date.day >= 7'd1) && (date_data.date.day <= 7'(len));
  assign ord_nxt   = valid_nxt ?
                     9'(9'(date_data.date.day) + days_before(date_data.date.month[3:0]) +
                        9'(date_data.date.month > 7'd2 && leap_nxt)) : 9'd0;
  // (month + 2) / 3 as a multiply by 171/512, exact for months up to 99.
  assign qprod     = (16'(date_data.date.month) + 16'd2) * 16'd171;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (!hold_a) va_r <= date_valid;
      if (!hold_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_a) begin
      ya_r     <= 14'(14'(date_data.date.year_hi) * 14'd100 + 14'(date_data.date.year_lo));
      ma_r     <= date_data.date.month;
      da_r     <= date_data.date.day;
      leapa_r  <= leap_nxt;
      valida_r <= valid_nxt;
      orda_r   <= ord_nxt;
      qa_r     <= qprod[14:9];
      hita_r   <= date_data.limit_hit;
    end
    if (!hold_b) begin
      value_r  <= 27'(27'(ya_r) * 27'd10000 + 27'(ma_r) * 27'd100 + 27'(da_r));
      yb_r     <= ya_r;
      mb_r     <= ma_r;
      db_r     <= da_r;
      qb_r     <= qa_r;
      leapb_r  <= leapa_r;
      validb_r <= valida_r;
      ordb_r   <= orda_r;
      remb_r   <= 9'(9'd365 + 9'(leapa_r) - orda_r);
      hitb_r   <= hita_r;
    end
  end

  assign out_valid          = vb_r;
  assign out_current_value  = value_r;
  assign out_year_part      = yb_r;
  assign out_month_part     = mb_r;
  assign out_day_part       = db_r;
  assign out_quarter_number = qb_r;
  assign out_leap_flag      = leapb_r;
  assign out_valid_flag     = validb_r;
  assign out_ordinal_day    = ordb_r;
  assign out_days_remaining = remb_r;
  assign out_limit_hit      = hitb_r;

endmodule

@@ design/packed_date_calendar_counter_top.sv @@
// Gregorian date counter holding one date packed as the decimal number YYYYMMDD.
// Each transfer queries, loads, or steps the date to the next or previous valid
// date, and yields one result with the date and its parts. The block takes one
// transfer per clock while the output is not stalled. Four stages split the
// loaded value into decimal digits by multiplying by a reciprocal of 100, one
// stage applies the command to the date register, and two stages rebuild the
// packed number and the derived fields. The throughput is set by the date
// register's step loop. A result that is stalled at the output holds only as
// many stages as are full behind it.
module packed_date_calendar_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [26:0] in_load_date,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [26:0] out_current_value,
  output logic [13:0] out_year_part,
  output logic [6:0]  out_month_part,
  output logic [6:0]  out_day_part,
  output logic [5:0]  out_quarter_number,
  output logic        out_leap_flag,
  output logic        out_valid_flag,
  output logic [8:0]  out_ordinal_day,
  output logic [8:0]  out_days_remaining,
  output logic        out_limit_hit
);
  import pdcal_pkg::*;

  logic   split_valid, split_stall;
  split_t split_data;
  logic   date_valid, date_stall;
  step_t  date_data;

  pdcal_split u_split (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_load_date (in_load_date),
    .split_valid  (split_valid),
    .split_stall  (split_stall),
    .split_data   (split_data)
  );

  pdcal_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .split_valid (split_valid),
    .split_stall (split_stall),
    .split_data  (split_data),
    .date_valid  (date_valid),
    .date_stall  (date_stall),
    .date_data   (date_data)
  );

  pdcal_fields u_fields (
    .clk                (clk),
    .rst_n              (rst_n),
    .date_valid         (date_valid),
    .date_stall         (date_stall),
    .date_data          (date_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_value  (out_current_value),
    .out_year_part      (out_year_part),
    .out_month_part     (out_month_part),
    .out_day_part       (out_day_part),
    .out_quarter_number (out_quarter_number),
    .out_leap_flag      (out_leap_flag),
    .out_valid_flag     (out_valid_flag),
    .out_ordinal_day    (out_ordinal_day),
    .out_days_remaining (out_days_remaining),
    .out_limit_hit      (out_limit_hit)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pdcal_pkg::*;

  localparam int unsigned LAST_DATE    = 99991231;
  localparam int unsigned FIRST_DATE   = 101;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          SETTLE       = 20;

  typedef struct packed {
    logic [26:0] value;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [5:0]  quarter;
    logic        leap;
    logic        valid;
    logic [8:0]  ordinal;
    logic [8:0]  remaining;
    logic        hit;
  } calendar_result_t;

  // A typed row carries the date and limit flag it must produce.
  typedef struct packed {
    cmd_t        cmd;
    logic [26:0] date;
    logic        typed;
    logic [26:0] value;
    logic        hit;
  } probe_row_t;

  localparam int NUM_ROWS = 25;

  probe_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_QUERY, 27'd0,         1'b1, 27'd0,         1'b0},
    '{CMD_PREV,  27'd0,         1'b1, 27'd0,         1'b1},
    '{CMD_NEXT,  27'h7FFFFFF,   1'b1, 27'd101,       1'b0},
    '{CMD_PREV,  27'd0,         1'b1, 27'd101,       1'b1},
    '{CMD_LOAD,  27'd99991231,  1'b1, 27'd99991231,  1'b0},
    '{CMD_NEXT,  27'd0,         1'b1, 27'd99991231,  1'b1},
    '{CMD_PREV,  27'd0,         1'b1, 27'd99991230,  1'b0},
    '{CMD_LOAD,  27'h7FFFFFF,   1'b1, 27'd134217727, 1'b0},
    '{CMD_NEXT,  27'd0,         1'b1, 27'd134217727, 1'b1},
    '{CMD_PREV,  27'd0,         1'b1, 27'd99991231,  1'b0},
    '{CMD_LOAD,  27'd20240228,  1'b0, 27'd0,         1'b0},
    '{CMD_NEXT,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_NEXT,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_PREV,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_LOAD,  27'd19000228,  1'b0, 27'd0,         1'b0},
    '{CMD_NEXT,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_LOAD,  27'd20230831,  1'b0, 27'd0,         1'b0},
    '{CMD_NEXT,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_LOAD,  27'd20231399,  1'b0, 27'd0,         1'b0},
    '{CMD_NEXT,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_LOAD,  27'd20230400,  1'b0, 27'd0,         1'b0},
    '{CMD_PREV,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_LOAD,  27'd10100,     1'b0, 27'd0,         1'b0},
    '{CMD_PREV,  27'd0,         1'b0, 27'd0,         1'b0},
    '{CMD_QUERY, 27'h5555555,   1'b0, 27'd0,         1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_QUERY;
  logic [26:0] in_load_date = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [26:0] out_current_value;
  logic [13:0] out_year_part;
  logic [6:0]  out_month_part;
  logic [6:0]  out_day_part;
  logic [5:0]  out_quarter_number;
  logic        out_leap_flag;
  logic        out_valid_flag;
  logic [8:0]  out_ordinal_day;
  logic [8:0]  out_days_remaining;
  logic        out_limit_hit;

  calendar_result_t expected_results[$];
  int unsigned      calendar_date = 0;
  int               items_sent = 0;
  int               mismatches = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  bit               no_gaps = 1'b0;
  bit               hold_off_req = 1'b0;

  packed_date_calendar_counter_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_load_date       (in_load_date),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_value  (out_current_value),
    .out_year_part      (out_year_part),
    .out_month_part     (out_month_part),
    .out_day_part       (out_day_part),
    .out_quarter_number (out_quarter_number),
    .out_leap_flag      (out_leap_flag),
    .out_valid_flag     (out_valid_flag),
    .out_ordinal_day    (out_ordinal_day),
    .out_days_remaining (out_days_remaining),
    .out_limit_hit      (out_limit_hit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Smallest valid date above v; zero means there is none in range.
  function automatic int unsigned date_after(int unsigned v);
    int unsigned y, m, d, r;
    if (v >= LAST_DATE) return 0;
    y = v / 10000;
    m = (v % 10000) / 100;
    d = v % 100;
    if (m == 0) r = y * 10000 + 101;
    else if (m > 12) r = (y + 1) * 10000 + 101;
    else if (d < month_days(y, m)) r = v + 1;
    else if (m < 12) r = y * 10000 + (m + 1) * 100 + 1;
    else r = (y + 1) * 10000 + 101;
    return (r > LAST_DATE) ? 0 : r;
  endfunction

  // Largest valid date below v; zero means there is none.
  function automatic int unsigned date_before(int unsigned v);
    int unsigned y, m, d, len;
    if (v <= FIRST_DATE) return 0;
    if (v > LAST_DATE) return LAST_DATE;
    y = v / 10000;
    m = (v % 10000) / 100;
    d = v % 100;
    if (m > 12) return y * 10000 + 1231;
    if (m >= 1) begin
      len = month_days(y, m);
      if (d > len) return y * 10000 + m * 100 + len;
      if (d > 1) return v - 1;
      if (m > 1) return y * 10000 + (m - 1) * 100 + month_days(y, m - 1);
    end
    if (y == 0) return 0;
    return (y - 1) * 10000 + 1231;
  endfunction

  function automatic calendar_result_t describe_date(int unsigned v, logic hit);
    calendar_result_t r;
    int unsigned y, m, d, ord;
    y = v / 10000;
    m = (v % 10000) / 100;
    d = v % 100;
    ord = 0;
    r.value = v[26:0];
    r.year = y[13:0];
    r.month = m[6:0];
    r.day = d[6:0];
    r.quarter = 6'((m + 2) / 3);
    r.leap = leap_year(y);
    r.valid = (m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m));
    if (r.valid) begin
      ord = d;
      for (int unsigned k = 1; k < m; k++) ord += month_days(y, k);
    end
    r.ordinal = ord[8:0];
    r.remaining = 9'(365 + r.leap - ord);
    r.hit = hit;
    return r;
  endfunction

  function automatic calendar_result_t advance_calendar(cmd_t cmd, logic [26:0] load);
    int unsigned target;
    logic hit;
    hit = 1'b0;
    case (cmd)
      CMD_LOAD: calendar_date = 32'(load);
      CMD_NEXT, CMD_PREV: begin
        target = (cmd == CMD_NEXT) ? date_after(calendar_date) : date_before(calendar_date);
        if (target == 0) hit = 1'b1;
        else calendar_date = target;
      end
      default: ;
    endcase
    return describe_date(calendar_date, hit);
  endfunction

  function automatic logic [26:0] random_bits();
    return 27'($urandom);
  endfunction

  function automatic int unsigned pick_valid_date();
    int unsigned y, m, d, len;
    case ($urandom_range(0, 9))
      0:       y = 0;
      1:       y = 9999;
      2:       y = $urandom_range(0, 99) * 100;
      default: y = $urandom_range(0, 9999);
    endcase
    m = $urandom_range(1, 12);
    len = month_days(y, m);
    case ($urandom_range(0, 4))
      0, 1:    d = len;
      2:       d = 1;
      default: d = $urandom_range(1, len);
    endcase
    return y * 10000 + m * 100 + d;
  endfunction

  task automatic pace();
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
    end
  endtask

  task automatic send_item(cmd_t cmd, logic [26:0] date, logic typed,
                           logic [26:0] typed_value, logic typed_hit);
    calendar_result_t want;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_load_date <= date;
    do @(posedge clk); while (in_stall);
    want = advance_calendar(cmd, date);
    if (typed) begin
      want = describe_date(32'(typed_value), typed_hit);
      calendar_date = 32'(typed_value);
    end
    expected_results.push_back(want);
    items_sent++;
    pace();
  endtask

  task automatic issue(cmd_t cmd, logic [26:0] date);
    send_item(cmd, date, 1'b0, '0, 1'b0);
  endtask

  task automatic run_steps(int n, int next_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 5) issue(CMD_QUERY, random_bits());
      else if ($urandom_range(0, 99) < next_pct) issue(CMD_NEXT, random_bits());
      else issue(CMD_PREV, random_bits());
    end
  endtask

  // Mostly well-formed load-and-walk runs; the rest are boundary walks,
  // malformed digit patterns and raw noise.
  task automatic random_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      issue(CMD_LOAD, 27'(pick_valid_date()));
      run_steps($urandom_range(1, 24), $urandom_range(0, 1) ? 90 : 10);
    end else if (kind < 70) begin
      if ($urandom_range(0, 1)) begin
        issue(CMD_LOAD, 27'(($urandom_range(0, 3) == 0) ? LAST_DATE + $urandom_range(0, 200)
                                                        : LAST_DATE - $urandom_range(0, 40)));
        run_steps($urandom_range(2, 16), 85);
      end else begin
        issue(CMD_LOAD, 27'($urandom_range(0, 300)));
        run_steps($urandom_range(2, 16), 15);
      end
    end else if (kind < 85) begin
      issue(CMD_LOAD, 27'($urandom_range(0, 9999) * 10000 + $urandom_range(0, 99) * 100
                          + $urandom_range(0, 99)));
      run_steps($urandom_range(1, 8), 50);
    end else begin
      repeat ($urandom_range(1, 6)) issue(cmd_t'($urandom_range(0, 3)), random_bits());
    end
  endtask

  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].date, directed_rows[i].typed,
                directed_rows[i].value, directed_rows[i].hit);
    end
    drain_results();

    // The receiver holds off while transfers keep coming, so the block backs up.
    hold_off_req = 1'b1;
    no_gaps = 1'b1;
    issue(CMD_LOAD, 27'(pick_valid_date()));
    run_steps(40, 50);
    no_gaps = 1'b0;
    drain_results();

    while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
      if (!paused && items_sent > NUM_ROWS + RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      random_sequence();
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((mode_left % 7) < 3);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    calendar_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with none expected, current_value %0d", out_current_value);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("current_value", 32'(want.value), 32'(out_current_value));
        check_field("year_part", 32'(want.year), 32'(out_year_part));
        check_field("month_part", 32'(want.month), 32'(out_month_part));
        check_field("day_part", 32'(want.day), 32'(out_day_part));
        check_field("quarter_number", 32'(want.quarter), 32'(out_quarter_number));
        check_field("leap_flag", 32'(want.leap), 32'(out_leap_flag));
        check_field("valid_flag", 32'(want.valid), 32'(out_valid_flag));
        check_field("ordinal_day", 32'(want.ordinal), 32'(out_ordinal_day));
        check_field("days_remaining", 32'(want.remaining), 32'(out_days_remaining));
        check_field("limit_hit", 32'(want.hit), 32'(out_limit_hit));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
design/pdcal_pkg.sv
design/pdcal_split.sv
design/pdcal_step.sv
design/pdcal_fields.sv
design/packed_date_calendar_counter_top.sv
bench/testbench.sv
